FILE: src/fstm_pkg.sv
// Shared types, constants and helpers for the frame schedule timing monitor.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fstm_pkg;

    localparam int DEF_FRAMES = 16;
    localparam int DEF_JOBS   = 16;

    localparam logic [15:0] DEF_ROUND_LIMIT = 16'd10;
    localparam logic [15:0] ROUND_MAX       = 16'hffff;
    localparam logic [31:0] COUNT_MAX       = 32'hffff_ffff;
    localparam logic [63:0] TIME_ONES       = 64'hffff_ffff_ffff_ffff;

    // result status codes
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_FRAME  = 3'd1;
    localparam logic [2:0] STATUS_FULL       = 3'd2;
    localparam logic [2:0] STATUS_IGNORED    = 3'd3;
    localparam logic [2:0] STATUS_NO_SAMPLES = 3'd4;

    // statistic selectors
    localparam logic [2:0] SEL_JOB_FIRST = 3'd3;
    localparam logic [2:0] SEL_LIMIT     = 3'd6;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_ACT    = 3'd1,
        CMD_FSTART = 3'd2,
        CMD_TSTART = 3'd3,
        CMD_TEND   = 3'd4,
        CMD_FEND   = 3'd5,
        CMD_READ   = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        frame_ok;
        logic [63:0] timestamp;
        logic [7:0]  frame_index;
        logic [7:0]  task_id;
        logic [3:0]  job_index;
        logic [2:0]  stat_select;
    } item_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        dispatch_valid;
        logic [7:0]  dispatch_task;
        logic        dispatch_frame_end;
        logic [31:0] stat_min;
        logic [31:0] stat_max;
        logic [31:0] stat_mean;
        logic [31:0] stat_count;
        logic        rounds_complete;
    } res_t;

    typedef struct packed {
        logic [63:0] min;
        logic [63:0] max;
        logic [63:0] sum;
        logic [31:0] samples;
    } stat_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v[63:32] != 32'd0) ? COUNT_MAX : v[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/fstm_div.sv
// Restoring divider for the statistic mean: 64-bit dividend, 32-bit divisor.
// One quotient bit per cycle. Depends on fstm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fstm_div
    import fstm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[63]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = 32'd0;
            cnt_next = 7'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 32'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/fstm_front.sv
// Front end: takes command beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on fstm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fstm_front
    import fstm_pkg::*;
#(
    parameter int FRAMES = DEF_FRAMES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [63:0] timestamp,
    input  wire logic [7:0]  frame_index,
    input  wire logic [7:0]  task_id,
    input  wire logic [3:0]  job_index,
    input  wire logic [2:0]  stat_select,
    output item_t            q_item,
    output logic             q_valid,
    input  back_ctl_t        ctl
);

    item_t       q_mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       in_item;

    always_comb
    begin
        in_item.cmd         = cmd_t'(command);
        in_item.frame_ok    = (32'(frame_index) < FRAMES);
        in_item.timestamp   = timestamp;
        in_item.frame_index = frame_index;
        in_item.task_id     = task_id;
        in_item.job_index   = job_index;
        in_item.stat_select = stat_select;
    end

    assign busy    = (cnt_reg == 2'd2) || ctl.clearing;
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !ctl.pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && ctl.pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/fstm_back.sv
// Back end: frame table, job time stores, statistic store and the sequencer
// that executes queued commands. Depends on fstm_pkg and fstm_div.
`timescale 1ns / 1ps
`default_nettype none

module fstm_back
    import fstm_pkg::*;
#(
    parameter int FRAMES = DEF_FRAMES,
    parameter int JOBS   = DEF_JOBS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  item_t            q_item,
    input  wire logic        q_valid,
    output back_ctl_t        ctl,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output res_t             res
);

    localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int JW    = $clog2(JOBS);
    localparam int NSLOT = FRAMES * JOBS;
    localparam int SLW   = $clog2(NSLOT);
    localparam int NSTAT = FRAMES * 3 + NSLOT * 3;
    localparam int STW   = $clog2(NSTAT);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_DISP     = 12'b0000_0000_0100,
        S_DISP_OUT = 12'b0000_0000_1000,
        S_RSTAT    = 12'b0000_0001_0000,
        S_RCHK     = 12'b0000_0010_0000,
        S_DIV      = 12'b0000_0100_0000,
        S_REC_RD   = 12'b0000_1000_0000,
        S_REC_WR   = 12'b0001_0000_0000,
        S_FT_WB    = 12'b0010_0000_0000,
        S_J_CHK    = 12'b0100_0000_0000,
        S_J_WB     = 12'b1000_0000_0000
    } state_t;

    function automatic logic [SLW-1:0] slot_of(input logic [FW-1:0] f,
                                               input logic [JW-1:0] j);
        slot_of = SLW'(32'(f) * JOBS + 32'(j));
    endfunction

    state_t state_reg, state_next;

    // control state
    logic [STW-1:0] clr_reg, clr_next;
    logic [15:0]    limit_reg;
    logic [15:0]    round_reg, round_next;
    logic [FW-1:0]  cf_reg, cf_next;
    logic [FW-1:0]  nf_reg, nf_next;
    logic [FW-1:0]  hf_reg, hf_next;
    logic [JW-1:0]  cj_reg, cj_next;
    logic [JW-1:0]  j_reg, j_next;
    logic [1:0]     op_reg, op_next;
    logic           rjob_reg, rjob_next;
    logic           rcf_reg, rcf_next;
    logic           done_reg, done_next;
    logic [JW-1:0]  jc_reg [FRAMES];
    logic           jc_we;

    // payload registers
    logic [63:0]    latch_reg, latch_next;
    logic [63:0]    pend_reg, pend_next;
    logic [63:0]    d_reg, d_next;
    logic [STW-1:0] rs_reg, rs_next;
    res_t           res_reg, res_next;

    // memories
    logic [7:0]  task_mem  [NSLOT];
    logic [63:0] start_mem [NSLOT];
    logic [63:0] end_mem   [NSLOT];
    logic [63:0] prev_mem  [NSLOT];
    logic [63:0] fa_mem    [FRAMES];
    logic [63:0] fs_mem    [FRAMES];
    logic [63:0] fpa_mem   [FRAMES];
    logic [63:0] fps_mem   [FRAMES];
    stat_t       stat_mem  [NSTAT];

    logic [7:0]  task_q;
    logic [63:0] js_q, je_q, jp_q, fa_q, fs_q, fpa_q, fps_q;
    stat_t       st_q;

    // memory control
    logic           clearing, clr_slot, clr_frame;
    logic           task_we, start_we, end_we, prev_we, fa_we, fpa_we;
    logic [SLW-1:0] task_wa;
    logic [STW-1:0] stat_ra;
    logic           stat_we;
    stat_t          stat_wd;

    // decode helpers
    logic [FW-1:0]  fi_idx;
    logic [JW-1:0]  ji_idx;
    logic [FW-1:0]  jc_addr;
    logic [JW-1:0]  jc_val;
    logic [SLW-1:0] slot_cur, slot_j;
    logic [STW-1:0] rec_s;
    logic [63:0]    rec_from, rec_to;
    logic [15:0]    round_inc;

    // divider
    logic        div_start, div_done;
    logic [63:0] div_q;

    fstm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (st_q.sum + 64'(st_q.samples >> 1)),
        .divisor  (st_q.samples),
        .done     (div_done),
        .quotient (div_q)
    );

    assign clearing  = (state_reg == S_CLEAR);
    assign clr_slot  = clearing && (32'(clr_reg) < NSLOT);
    assign clr_frame = clearing && (32'(clr_reg) < FRAMES);
    assign fi_idx    = q_item.frame_index[FW-1:0];
    assign ji_idx    = JW'(q_item.job_index);
    assign jc_addr   = ((state_reg == S_IDLE) && (q_item.cmd == CMD_ADD)) ? fi_idx : cf_reg;
    assign jc_val    = jc_reg[jc_addr];
    assign slot_cur  = slot_of(cf_reg, cj_reg);
    assign slot_j    = slot_of(cf_reg, j_reg);
    assign task_wa   = slot_of(fi_idx, jc_val);
    assign round_inc = round_reg + 16'd1;
    assign cfg_ready = 1'b1;

    // record operand selection: frame pass or job pass
    always_comb
    begin
        rec_s    = '0;
        rec_from = 64'd0;
        rec_to   = 64'd0;
        if (!rjob_reg)
        begin
            rec_s = STW'(32'(cf_reg) * 3 + 32'(op_reg));
            case (op_reg)
                2'd0:
                begin
                    rec_from = fpa_q;
                    rec_to   = fa_q;
                end
                2'd1:
                begin
                    rec_from = fps_q;
                    rec_to   = fs_q;
                end
                default:
                begin
                    rec_from = fa_q;
                    rec_to   = fs_q;
                end
            endcase
        end
        else
        begin
            case (op_reg)
                2'd0:
                begin
                    rec_s    = STW'(FRAMES * 3 + 32'(slot_j) * 3 + 2);
                    rec_from = pend_reg;
                    rec_to   = js_q;
                end
                2'd1:
                begin
                    rec_s    = STW'(FRAMES * 3 + 32'(slot_j) * 3 + 1);
                    rec_from = js_q;
                    rec_to   = je_q;
                end
                default:
                begin
                    rec_s    = STW'(FRAMES * 3 + 32'(slot_j) * 3);
                    rec_from = jp_q;
                    rec_to   = js_q;
                end
            endcase
        end
    end

    assign stat_ra = (state_reg == S_REC_RD) ? rec_s : rs_reg;

    always_comb
    begin
        stat_wd.min     = (st_q.min > d_reg) ? d_reg : st_q.min;
        stat_wd.max     = (st_q.max < d_reg) ? d_reg : st_q.max;
        stat_wd.sum     = st_q.sum + d_reg;
        stat_wd.samples = (st_q.samples != COUNT_MAX) ? st_q.samples + 32'd1 : st_q.samples;
        if (clearing)
        begin
            stat_wd.min     = TIME_ONES;
            stat_wd.max     = 64'd0;
            stat_wd.sum     = 64'd0;
            stat_wd.samples = 32'd0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        round_next   = round_reg;
        cf_next      = cf_reg;
        nf_next      = nf_reg;
        hf_next      = hf_reg;
        cj_next      = cj_reg;
        j_next       = j_reg;
        op_next      = op_reg;
        rjob_next    = rjob_reg;
        rcf_next     = rcf_reg;
        latch_next   = latch_reg;
        pend_next    = pend_reg;
        d_next       = d_reg;
        rs_next      = rs_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        ctl.pop      = 1'b0;
        ctl.clearing = clearing;
        jc_we        = 1'b0;
        task_we      = 1'b0;
        start_we     = 1'b0;
        end_we       = 1'b0;
        prev_we      = 1'b0;
        fa_we        = 1'b0;
        fpa_we       = 1'b0;
        stat_we      = clearing;
        div_start    = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + STW'(1);
                if (32'(clr_reg) == NSTAT - 1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (q_valid)
                begin
                    ctl.pop  = 1'b1;
                    res_next = '0;
                    case (q_item.cmd)
                        CMD_ADD:
                        begin
                            done_next = 1'b1;
                            if (!q_item.frame_ok)
                            begin
                                res_next.status = STATUS_BAD_FRAME;
                            end
                            else if (32'(jc_val) >= JOBS - 1)
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                task_we = 1'b1;
                                jc_we   = 1'b1;
                                if (fi_idx > hf_reg)
                                begin
                                    hf_next = fi_idx;
                                end
                            end
                        end
                        CMD_ACT:
                        begin
                            done_next = 1'b1;
                            if (round_reg >= limit_reg)
                            begin
                                res_next.status = STATUS_IGNORED;
                            end
                            else
                            begin
                                latch_next = q_item.timestamp;
                            end
                        end
                        CMD_FSTART:
                        begin
                            cf_next    = nf_reg;
                            cj_next    = '0;
                            fa_we      = 1'b1;
                            state_next = S_DISP;
                        end
                        CMD_TSTART:
                        begin
                            start_we  = 1'b1;
                            done_next = 1'b1;
                        end
                        CMD_TEND:
                        begin
                            end_we = 1'b1;
                            if (32'(cj_reg) < JOBS - 1)
                            begin
                                cj_next = cj_reg + JW'(1);
                            end
                            state_next = S_DISP;
                        end
                        CMD_FEND:
                        begin
                            rcf_next = 1'b0;
                            if (nf_reg < hf_reg)
                            begin
                                nf_next = nf_reg + FW'(1);
                            end
                            else
                            begin
                                nf_next = '0;
                                if (round_reg != ROUND_MAX)
                                begin
                                    round_next = round_inc;
                                    rcf_next   = (round_inc == limit_reg);
                                end
                            end
                            rjob_next  = 1'b0;
                            op_next    = 2'd0;
                            state_next = S_REC_RD;
                        end
                        CMD_READ:
                        begin
                            if (!q_item.frame_ok)
                            begin
                                res_next.status = STATUS_BAD_FRAME;
                                done_next       = 1'b1;
                            end
                            else if (q_item.stat_select < SEL_JOB_FIRST)
                            begin
                                rs_next    = STW'(32'(fi_idx) * 3 + 32'(q_item.stat_select));
                                state_next = S_RSTAT;
                            end
                            else if (q_item.stat_select < SEL_LIMIT &&
                                     32'(q_item.job_index) < JOBS)
                            begin
                                rs_next    = STW'(FRAMES * 3 + 32'(slot_of(fi_idx, ji_idx)) * 3
                                                  + 32'(q_item.stat_select - SEL_JOB_FIRST));
                                state_next = S_RSTAT;
                            end
                            else
                            begin
                                res_next.status = STATUS_NO_SAMPLES;
                                done_next       = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_DISP:
            begin
                state_next = S_DISP_OUT;
            end

            S_DISP_OUT:
            begin
                res_next.dispatch_valid = 1'b1;
                if (cj_reg < jc_val)
                begin
                    res_next.dispatch_task = task_q;
                end
                else
                begin
                    res_next.dispatch_frame_end = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_RSTAT:
            begin
                state_next = S_RCHK;
            end

            S_RCHK:
            begin
                if (st_q.samples == 32'd0)
                begin
                    res_next.status = STATUS_NO_SAMPLES;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.stat_min   = sat32(st_q.min);
                    res_next.stat_max   = sat32(st_q.max);
                    res_next.stat_mean  = sat32(div_q);
                    res_next.stat_count = st_q.samples;
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_REC_RD, S_REC_WR:
            begin
                if (state_reg == S_REC_RD && rec_from != 64'd0)
                begin
                    d_next     = rec_to - rec_from;
                    state_next = S_REC_WR;
                end
                else
                begin
                    stat_we = (state_reg == S_REC_WR);
                    if (op_reg != 2'd2)
                    begin
                        op_next    = op_reg + 2'd1;
                        state_next = S_REC_RD;
                    end
                    else
                    begin
                        op_next    = 2'd0;
                        state_next = rjob_reg ? S_J_WB : S_FT_WB;
                    end
                end
            end

            S_FT_WB:
            begin
                fpa_we     = 1'b1;
                pend_next  = fs_q;
                j_next     = '0;
                state_next = S_J_CHK;
            end

            S_J_CHK:
            begin
                if (j_reg < jc_val)
                begin
                    rjob_next  = 1'b1;
                    op_next    = 2'd0;
                    state_next = S_REC_RD;
                end
                else
                begin
                    res_next.rounds_complete = rcf_reg;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            S_J_WB:
            begin
                prev_we    = 1'b1;
                pend_next  = je_q;
                j_next     = j_reg + JW'(1);
                state_next = S_J_CHK;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            limit_reg <= DEF_ROUND_LIMIT;
            round_reg <= 16'd0;
            cf_reg    <= '0;
            nf_reg    <= '0;
            hf_reg    <= '0;
            cj_reg    <= '0;
            j_reg     <= '0;
            op_reg    <= 2'd0;
            rjob_reg  <= 1'b0;
            rcf_reg   <= 1'b0;
            done_reg  <= 1'b0;
            latch_reg <= 64'd0;
            for (int i = 0; i < FRAMES; i++)
            begin
                jc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            round_reg <= round_next;
            cf_reg    <= cf_next;
            nf_reg    <= nf_next;
            hf_reg    <= hf_next;
            cj_reg    <= cj_next;
            j_reg     <= j_next;
            op_reg    <= op_next;
            rjob_reg  <= rjob_next;
            rcf_reg   <= rcf_next;
            done_reg  <= done_next;
            latch_reg <= latch_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (jc_we)
            begin
                jc_reg[fi_idx] <= jc_val + JW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        d_reg    <= d_next;
        rs_reg   <= rs_next;
        res_reg  <= res_next;
    end

    // task table: no reset, only entries below the job count are read
    always_ff @(posedge clk)
    begin
        if (task_we)
        begin
            task_mem[task_wa] <= q_item.task_id;
        end
        task_q <= task_mem[slot_cur];
    end

    always_ff @(posedge clk)
    begin
        if (clr_slot || start_we)
        begin
            start_mem[clr_slot ? clr_reg[SLW-1:0] : slot_cur] <=
                clr_slot ? 64'd0 : q_item.timestamp;
        end
        js_q <= start_mem[slot_j];
    end

    always_ff @(posedge clk)
    begin
        if (clr_slot || end_we)
        begin
            end_mem[clr_slot ? clr_reg[SLW-1:0] : slot_cur] <=
                clr_slot ? 64'd0 : q_item.timestamp;
        end
        je_q <= end_mem[slot_j];
    end

    always_ff @(posedge clk)
    begin
        if (clr_slot || prev_we)
        begin
            prev_mem[clr_slot ? clr_reg[SLW-1:0] : slot_j] <= clr_slot ? 64'd0 : js_q;
        end
        jp_q <= prev_mem[slot_j];
    end

    always_ff @(posedge clk)
    begin
        if (clr_frame || fa_we)
        begin
            fa_mem[clr_frame ? clr_reg[FW-1:0] : nf_reg] <= clr_frame ? 64'd0 : latch_reg;
            fs_mem[clr_frame ? clr_reg[FW-1:0] : nf_reg] <=
                clr_frame ? 64'd0 : q_item.timestamp;
        end
        fa_q <= fa_mem[cf_reg];
        fs_q <= fs_mem[cf_reg];
    end

    always_ff @(posedge clk)
    begin
        if (clr_frame || fpa_we)
        begin
            fpa_mem[clr_frame ? clr_reg[FW-1:0] : cf_reg] <= clr_frame ? 64'd0 : fa_q;
            fps_mem[clr_frame ? clr_reg[FW-1:0] : cf_reg] <= clr_frame ? 64'd0 : fs_q;
        end
        fpa_q <= fpa_mem[cf_reg];
        fps_q <= fps_mem[cf_reg];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[clearing ? clr_reg : rec_s] <= stat_wd;
        end
        st_q <= stat_mem[stat_ra];
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

FILE: src/frame_schedule_timing_monitor_core.sv
// Frame schedule timing monitor top: command front end, two-beat queue and back end.
// Depends on fstm_pkg, fstm_front and fstm_back.
// Throughput: one command at a time in the back end, two more queued; no receiver stall.
// Reset: a clearing pass over all FRAMES*3 + FRAMES*JOBS*3 statistic entries (816) holds busy; cfg lands.
`timescale 1ns / 1ps
`default_nettype none

module frame_schedule_timing_monitor_core
    import fstm_pkg::*;
#(
    parameter int FRAMES = DEF_FRAMES,
    parameter int JOBS   = DEF_JOBS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // command beat
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [63:0] timestamp,
    input  wire logic [7:0]  frame_index,
    input  wire logic [7:0]  task_id,
    input  wire logic [3:0]  job_index,
    input  wire logic [2:0]  stat_select,

    // round limit register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,

    // result beat
    output logic             done,
    output logic [2:0]       status,
    output logic             dispatch_valid,
    output logic [7:0]       dispatch_task,
    output logic             dispatch_frame_end,
    output logic [31:0]      stat_min,
    output logic [31:0]      stat_max,
    output logic [31:0]      stat_mean,
    output logic [31:0]      stat_count,
    output logic             rounds_complete
);

    item_t     q_item;
    logic      q_valid;
    back_ctl_t ctl;
    res_t      res;

    // front end: classification and queue, so the producer can keep issuing
    // while the back end walks a frame, until the queue is full
    fstm_front #(
        .FRAMES (FRAMES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .timestamp   (timestamp),
        .frame_index (frame_index),
        .task_id     (task_id),
        .job_index   (job_index),
        .stat_select (stat_select),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .ctl         (ctl)
    );

    // back end: all table and statistic state, statistic folding and the mean divider
    fstm_back #(
        .FRAMES (FRAMES),
        .JOBS   (JOBS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .ctl       (ctl),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .res       (res)
    );

    assign status             = res.status;
    assign dispatch_valid     = res.dispatch_valid;
    assign dispatch_task      = res.dispatch_task;
    assign dispatch_frame_end = res.dispatch_frame_end;
    assign stat_min           = res.stat_min;
    assign stat_max           = res.stat_max;
    assign stat_mean          = res.stat_mean;
    assign stat_count         = res.stat_count;
    assign rounds_complete    = res.rounds_complete;

endmodule

`default_nettype wire
